>>> sv/lhbd_pkg.sv
package lhbd_pkg;

    localparam int HOLD_TICKS = 100;
    localparam int HOLD_W = 7;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] CFG_SINGLE_SHOT = 2'd0;
    localparam logic [1:0] CFG_LEVEL_MODE = 2'd1;
    localparam logic [1:0] CFG_RISING_ACTIVE = 2'd2;
    localparam logic [1:0] CFG_UPSIDE_DOWN = 2'd3;

    localparam logic [1:0] ANODE_ONE = 2'd1;
    localparam logic [1:0] ANODE_TWO = 2'd2;

    typedef struct packed {
        logic single_shot;
        logic level_mode;
        logic rising_active;
        logic upside_down;
    } cfg_t;

    // One refresh request as handed from the capture side to the digit scanner.
    typedef struct packed {
        logic [7:0] shown_byte;
        logic       point_on;
    } tick_t;

    // Lit-segment pattern per hex digit, bits 7..0 = C,G,DP,B,A,D,E,F.
    function automatic logic [7:0] glyph_lit(input logic [3:0] nib);
        logic [7:0] g;
        begin
            unique case (nib)
                4'h0: g = 8'h9F;
                4'h1: g = 8'h90;
                4'h2: g = 8'h5E;
                4'h3: g = 8'hDC;
                4'h4: g = 8'hD1;
                4'h5: g = 8'hCD;
                4'h6: g = 8'hCF;
                4'h7: g = 8'h98;
                4'h8: g = 8'hDF;
                4'h9: g = 8'hDD;
                4'hA: g = 8'hDB;
                4'hB: g = 8'hC7;
                4'hC: g = 8'h0F;
                4'hD: g = 8'hD6;
                4'hE: g = 8'h4F;
                4'hF: g = 8'h4B;
                default: g = 8'h00;
            endcase
            return g;
        end
    endfunction

    // 180 degree rotation swaps A/D, B/E and C/F; G and DP stay put.
    function automatic logic [7:0] rotate_glyph(input logic [7:0] d);
        logic [7:0] t;
        begin
            t = {d[0], d[6], d[5], d[1], d[2], d[3], d[4], d[7]};
            return t;
        end
    endfunction

endpackage

>>> sv/lhbd_front.sv
module lhbd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lhbd_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           data_in,
    input  logic                 latch_level,
    input  logic                 queue_full,
    output logic                 push,
    output lhbd_pkg::tick_t      push_item
);
    import lhbd_pkg::*;

    logic [7:0]        shown_byte_reg, shown_byte_next;
    logic              frozen_reg, frozen_next;
    logic              point_on_reg, point_on_next;
    logic [HOLD_W-1:0] hold_count_reg, hold_count_next;
    logic              prev_latch_reg;
    logic              at_active;
    logic              capture;
    logic [HOLD_W-1:0] hold_inc;

    assign in_ready = !queue_full;
    assign push = in_valid && in_ready;

    assign at_active = (latch_level == cfg.rising_active);
    assign capture = at_active && ((latch_level != prev_latch_reg) || cfg.level_mode)
                     && !frozen_reg;

    always_comb
    begin
        shown_byte_next = shown_byte_reg;
        frozen_next = frozen_reg;
        point_on_next = point_on_reg;
        hold_count_next = hold_count_reg;
        if (capture)
        begin
            shown_byte_next = data_in;
            point_on_next = 1'b1;
            if (cfg.single_shot)
            begin
                frozen_next = 1'b1;
            end
            else
            begin
                hold_count_next = HOLD_W'(1);
            end
        end
        if (!cfg.single_shot && frozen_next)
        begin
            frozen_next = 1'b0;
            point_on_next = 1'b0;
        end
        hold_inc = hold_count_next + HOLD_W'(1);
        if (hold_count_next != '0)
        begin
            hold_count_next = hold_inc;
            // A wrap to zero also ends the point timer.
            if (hold_inc > HOLD_W'(HOLD_TICKS) || hold_inc == '0)
            begin
                point_on_next = 1'b0;
                hold_count_next = '0;
            end
        end
    end

    assign push_item.shown_byte = shown_byte_next;
    assign push_item.point_on = point_on_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shown_byte_reg <= '0;
            frozen_reg <= 1'b0;
            point_on_reg <= 1'b0;
            hold_count_reg <= '0;
            prev_latch_reg <= 1'b1;
        end
        else if (push)
        begin
            shown_byte_reg <= shown_byte_next;
            frozen_reg <= frozen_next;
            point_on_reg <= point_on_next;
            hold_count_reg <= hold_count_next;
            prev_latch_reg <= latch_level;
        end
    end

endmodule

>>> sv/lhbd_queue.sv
module lhbd_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lhbd_pkg::tick_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output lhbd_pkg::tick_t pop_item
);
    import lhbd_pkg::*;

    tick_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    assign full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

>>> sv/lhbd_back.sv
module lhbd_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            upside_down,
    input  logic            not_empty,
    input  lhbd_pkg::tick_t pop_item,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      seg_drive,
    output logic [1:0]      digit_select,
    output logic            last_of_tick
);
    import lhbd_pkg::*;

    tick_t      cur_reg;
    logic       valid_reg;
    logic       phase_reg;
    logic       word_done;
    logic [3:0] nibble;
    logic [7:0] dark;
    logic [7:0] oriented;
    logic [1:0] anode;

    assign word_done = valid_reg && out_ready;
    // Load a new request when idle or when the second word is leaving.
    assign pop = not_empty && (!valid_reg || (word_done && phase_reg));

    assign nibble = phase_reg ? cur_reg.shown_byte[7:4] : cur_reg.shown_byte[3:0];
    assign dark = ~glyph_lit(nibble);
    assign oriented = upside_down ? rotate_glyph(dark) : dark;
    assign anode = (phase_reg ^ upside_down) ? ANODE_TWO : ANODE_ONE;

    // The decimal point belongs to whichever word lands on anode one.
    always_comb
    begin
        seg_drive = oriented;
        if (anode == ANODE_ONE && cur_reg.point_on)
        begin
            seg_drive[5] = 1'b0;
        end
    end

    assign digit_select = anode;
    assign last_of_tick = phase_reg;
    assign out_valid = valid_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
            phase_reg <= 1'b0;
        end
        else if (word_done)
        begin
            if (phase_reg)
            begin
                valid_reg <= 1'b0;
                phase_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= 1'b1;
            end
        end
    end

endmodule

>>> sv/latched_hex_byte_display.sv
// Each request (one refresh tick) yields two digit words on the output channel.
// The first word passes through the queue slot and then the scanner's current-request register
// before it is valid, when the digit scanner is idle.
// The digit scanner emits one word a cycle while out_ready is high, two words per request;
// a two-entry queue lets requests be taken while words are still waiting.
// Reset (rst_n low, asynchronous) clears the display state and queue; the pin is
// assumed high, and the registers return to single shot and upside-down mode.
module latched_hex_byte_display (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_in,
    input  logic       latch_level,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] seg_drive,
    output logic [1:0] digit_select,
    output logic       last_of_tick
);
    import lhbd_pkg::*;

    cfg_t  cfg_reg;
    logic  queue_full;
    logic  push;
    tick_t push_item;
    logic  pop;
    logic  not_empty;
    tick_t pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.single_shot <= 1'b1;
            cfg_reg.level_mode <= 1'b0;
            cfg_reg.rising_active <= 1'b0;
            cfg_reg.upside_down <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SINGLE_SHOT:   cfg_reg.single_shot <= cfg_data;
                CFG_LEVEL_MODE:    cfg_reg.level_mode <= cfg_data;
                CFG_RISING_ACTIVE: cfg_reg.rising_active <= cfg_data;
                CFG_UPSIDE_DOWN:   cfg_reg.upside_down <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    lhbd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_in     (data_in),
        .latch_level (latch_level),
        .queue_full  (queue_full),
        .push        (push),
        .push_item   (push_item)
    );

    lhbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_item  (pop_item)
    );

    lhbd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .upside_down  (cfg_reg.upside_down),
        .not_empty    (not_empty),
        .pop_item     (pop_item),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .seg_drive    (seg_drive),
        .digit_select (digit_select),
        .last_of_tick (last_of_tick)
    );

endmodule

>>> sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lhbd_pkg::*;

    // Lit-segment patterns for hex digits 0..F, digit 0 in the low byte.
    localparam logic [127:0] HEX_LIT = {
        8'h4B, 8'h4F, 8'hD6, 8'h0F, 8'hC7, 8'hDB, 8'hDD, 8'hDF,
        8'h98, 8'hCF, 8'hCD, 8'hD1, 8'hDC, 8'h5E, 8'h90, 8'h9F
    };

    typedef struct packed {
        logic [7:0] seg;
        logic [1:0] anode;
        logic       last_word;
    } digit_word_t;

    class hex_display_scoreboard;
        cfg_t        regs;
        logic [7:0]  shown;
        logic        frozen;
        logic        point_on;
        logic [6:0]  hold;
        logic        prev_pin;
        digit_word_t pending_digit_words[$];
        int          errors;

        function new();
            regs.single_shot = 1'b1;
            regs.level_mode = 1'b0;
            regs.rising_active = 1'b0;
            regs.upside_down = 1'b1;
            shown = 8'h00;
            frozen = 1'b0;
            point_on = 1'b0;
            hold = 7'd0;
            prev_pin = 1'b1;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic val);
            case (idx)
                CFG_SINGLE_SHOT:   regs.single_shot = val;
                CFG_LEVEL_MODE:    regs.level_mode = val;
                CFG_RISING_ACTIVE: regs.rising_active = val;
                CFG_UPSIDE_DOWN:   regs.upside_down = val;
                default: ;
            endcase
        endfunction

        function digit_word_t digit_word(logic [3:0] nib, logic [1:0] logical, logic last_word);
            digit_word_t w;
            logic [7:0]  d;
            logic [7:0]  mirrored;
            d = ~HEX_LIT[nib*8 +: 8];
            w.anode = logical;
            if (regs.upside_down)
            begin
                // Turning the glyph around swaps A with D, B with E and C with F.
                mirrored = d;
                mirrored[3] = d[2];
                mirrored[2] = d[3];
                mirrored[4] = d[1];
                mirrored[1] = d[4];
                mirrored[7] = d[0];
                mirrored[0] = d[7];
                d = mirrored;
                w.anode = (logical == ANODE_TWO) ? ANODE_ONE : ANODE_TWO;
            end
            if (w.anode == ANODE_ONE && point_on)
                d[5] = 1'b0;
            w.seg = d;
            w.last_word = last_word;
            return w;
        endfunction

        function void note_request(logic [7:0] data, logic pin);
            logic at_active;
            logic pin_edge;
            logic level_hit;
            at_active = (pin == regs.rising_active);
            pin_edge = at_active && (pin != prev_pin);
            level_hit = at_active && regs.level_mode;
            if ((pin_edge || level_hit) && !frozen)
            begin
                shown = data;
                point_on = 1'b1;
                if (regs.single_shot)
                    frozen = 1'b1;
                else
                    hold = 7'd1;
            end
            if (!regs.single_shot && frozen)
            begin
                frozen = 1'b0;
                point_on = 1'b0;
            end
            if (hold != 7'd0)
            begin
                hold = hold + 7'd1;
                if (hold > HOLD_TICKS || hold == 7'd0)
                begin
                    point_on = 1'b0;
                    hold = 7'd0;
                end
            end
            prev_pin = pin;
            pending_digit_words.push_back(digit_word(shown[3:0], ANODE_ONE, 1'b0));
            pending_digit_words.push_back(digit_word(shown[7:4], ANODE_TWO, 1'b1));
        endfunction

        function void check_word(logic [7:0] seg, logic [1:0] anode, logic last_word);
            digit_word_t want;
            if (pending_digit_words.size() == 0)
            begin
                $display("%0t: unexpected digit word seg=%h anode=%0d last=%0d",
                         $time, seg, anode, last_word);
                errors++;
                return;
            end
            want = pending_digit_words.pop_front();
            if (seg !== want.seg)
            begin
                $display("%0t: seg_drive expected %h actual %h", $time, want.seg, seg);
                errors++;
            end
            if (anode !== want.anode)
            begin
                $display("%0t: digit_select expected %0d actual %0d", $time, want.anode, anode);
                errors++;
            end
            if (last_word !== want.last_word)
            begin
                $display("%0t: last_of_tick expected %0d actual %0d",
                         $time, want.last_word, last_word);
                errors++;
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic       cfg_data;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_in;
    logic       latch_level;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] seg_drive;
    logic [1:0] digit_select;
    logic       last_of_tick;

    hex_display_scoreboard sb = new();

    int gap_odds = 4;
    int stall_odds = 4;
    int stall_left = 0;

    latched_hex_byte_display i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_in      (data_in),
        .latch_level  (latch_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .seg_drive    (seg_drive),
        .digit_select (digit_select),
        .last_of_tick (last_of_tick)
    );

    always #5 clk = ~clk;

    // Output side: accept words, with random stall bursts.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        begin
            stall_left = $urandom_range(0, 8);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_word(seg_drive, digit_select, last_of_tick);
    end

    task automatic send_tick(input logic [7:0] data, input logic pin);
        in_valid <= 1'b1;
        data_in <= data;
        latch_level <= pin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(data, pin);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic wait_for_display_idle();
        in_valid <= 1'b0;
        while (sb.pending_digit_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // Registers are only touched once every pending word has been shown.
    task automatic apply_setting(input logic single, input logic level,
                                 input logic rising, input logic upside);
        wait_for_display_idle();
        write_cfg(CFG_SINGLE_SHOT, single);
        write_cfg(CFG_LEVEL_MODE, level);
        write_cfg(CFG_RISING_ACTIVE, rising);
        write_cfg(CFG_UPSIDE_DOWN, upside);
        cfg_we <= 1'b0;
    endtask

    // Random pin activity made of runs, mostly short, sometimes long enough for
    // the point timer to run out. The phase ends with a forced edge to the active level.
    task automatic run_phase(input int count, input logic active);
        logic       pin;
        logic [7:0] data;
        int         run_left;
        pin = ~active;
        run_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (i >= count - 2)
                pin = (i == count - 1) ? active : ~active;
            else if ($urandom_range(0, 9) == 0)
                pin = 1'($urandom_range(0, 1));
            else
            begin
                if (run_left == 0)
                begin
                    pin = ~pin;
                    run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 130)
                                                           : $urandom_range(1, 5);
                end
                run_left--;
            end
            case ($urandom_range(0, 9))
                0: data = 8'h00;
                1: data = 8'hFF;
                default: data = 8'($urandom_range(0, 255));
            endcase
            send_tick(data, pin);
        end
    endtask

    initial
    begin
        logic [3:0] s;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_SINGLE_SHOT;
        cfg_data <= 1'b0;
        in_valid <= 1'b0;
        data_in <= 8'h00;
        latch_level <= 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: falling edge captures once, then the display stays frozen.
        send_tick(8'hFF, 1'b1);
        send_tick(8'hA5, 1'b0);
        send_tick(8'h00, 1'b1);
        send_tick(8'h3C, 1'b0);

        // Recapture on rising edges, upright; walk every hex digit through.
        apply_setting(1'b0, 1'b0, 1'b1, 1'b0);
        for (int k = 0; k < 8; k++)
        begin
            send_tick(8'($urandom_range(0, 255)), 1'b0);
            send_tick({4'(2 * k + 1), 4'(2 * k)}, 1'b1);
        end

        // Transparent latch while the pin stays high.
        apply_setting(1'b0, 1'b1, 1'b1, 1'b1);
        send_tick(8'h00, 1'b1);
        send_tick(8'hFF, 1'b1);
        send_tick(8'h5A, 1'b0);

        // Every setting once; single shot alternates so a running point timer
        // is carried into single shot mode.
        for (int p = 0; p < 16; p++)
        begin
            s = p[3:0];
            apply_setting(s[0], s[1], s[2], s[3]);
            if (p >= 14)
            begin
                gap_odds = 0;
                stall_odds = 0;
            end
            else if (p % 4 == 3)
            begin
                gap_odds = 0;
                stall_odds = 0;
            end
            else
            begin
                gap_odds = $urandom_range(2, 8);
                stall_odds = $urandom_range(2, 8);
            end
            run_phase(75, s[2]);
        end

        wait_for_display_idle();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_digit_words.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
sv/lhbd_pkg.sv
sv/lhbd_front.sv
sv/lhbd_queue.sv
sv/lhbd_back.sv
sv/latched_hex_byte_display.sv
sim/tb_top.sv
